@@ src/erd_pkg.sv @@
package erd_pkg;

  localparam int unsigned FLOOR_W  = 8;
  localparam int unsigned CAP_W    = 8;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CAR_W    = 2;
  localparam int unsigned CAR_SLOTS = 4;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned SETUP_W  = 32;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned PROD_W   = 24;

  // setup register byte lanes
  localparam int unsigned LO_LSB   = 0;
  localparam int unsigned TOP_LSB  = 8;
  localparam int unsigned CUR_LSB  = 16;
  localparam int unsigned CAP_LSB  = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_WALK
  } state_t;

  // best-so-far record passed down the cell row
  typedef struct packed {
    logic               s_found;
    logic [CAR_W-1:0]   s_idx;
    logic [NUM_W-1:0]   s_num;
    logic [CAP_W-1:0]   s_cap;
    logic               f_found;
    logic [CAR_W-1:0]   f_idx;
    logic [FLOOR_W-1:0] f_gap;
  } hop_t;

endpackage

@@ src/erd_cell.sv @@
module erd_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_sel,
  input  logic [erd_pkg::SETUP_W-1:0]    cfg_data,
  input  logic [erd_pkg::FLOOR_W-1:0]    start_floor,
  input  logic [erd_pkg::FLOOR_W-1:0]    end_floor,
  input  logic                           inc,
  input  erd_pkg::hop_t                  tok_in,
  output erd_pkg::hop_t                  tok_out
);

  logic [erd_pkg::SETUP_W-1:0] setup_r;
  logic [erd_pkg::COUNT_W-1:0] count_r;

  logic [erd_pkg::FLOOR_W-1:0] lo, top, cur;
  logic [erd_pkg::CAP_W-1:0]   cap;
  logic                        in_a, in_b;
  logic [erd_pkg::FLOOR_W-1:0] gap;

  logic                        q_s_r, q_s_nxt;
  logic                        q_f_r, q_f_nxt;
  logic [erd_pkg::FLOOR_W-1:0] gap_r, gap_nxt;
  logic [erd_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [erd_pkg::CAP_W-1:0]   cap_r, cap_nxt;

  logic [erd_pkg::PROD_W-1:0]  prod_own, prod_best;
  logic                        take_s, take_f;
  erd_pkg::hop_t               tok_r, tok_nxt;

  assign lo  = setup_r[erd_pkg::LO_LSB  +: erd_pkg::FLOOR_W];
  assign top = setup_r[erd_pkg::TOP_LSB +: erd_pkg::FLOOR_W];
  assign cur = setup_r[erd_pkg::CUR_LSB +: erd_pkg::FLOOR_W];
  assign cap = setup_r[erd_pkg::CAP_LSB +: erd_pkg::CAP_W];

  always_comb begin
    in_a    = (start_floor >= lo) && (start_floor <= top);
    in_b    = (end_floor >= lo) && (end_floor <= top);
    gap     = (cur > start_floor) ? (cur - start_floor) : (start_floor - cur);
    q_s_nxt = in_a && in_b && (count_r < cap);
    q_f_nxt = in_a;
    gap_nxt = gap;
    cap_nxt = cap;
    num_nxt = erd_pkg::NUM_W'(gap) * erd_pkg::NUM_W'(cap) + erd_pkg::NUM_W'(count_r);
  end

  always_ff @(posedge clk) begin
    q_s_r <= q_s_nxt;
    q_f_r <= q_f_nxt;
    gap_r <= gap_nxt;
    num_r <= num_nxt;
    cap_r <= cap_nxt;
  end

  // exact score compare by cross products
  always_comb begin
    prod_own  = erd_pkg::PROD_W'(num_r) * erd_pkg::PROD_W'(tok_in.s_cap);
    prod_best = erd_pkg::PROD_W'(tok_in.s_num) * erd_pkg::PROD_W'(cap_r);
    take_s    = q_s_r && (!tok_in.s_found || (prod_own < prod_best));
    take_f    = q_f_r && (!tok_in.f_found || (gap_r < tok_in.f_gap));
    tok_nxt   = tok_in;
    if (take_s) begin
      tok_nxt.s_found = 1'b1;
      tok_nxt.s_idx   = erd_pkg::CAR_W'(CELL_IDX);
      tok_nxt.s_num   = num_r;
      tok_nxt.s_cap   = cap_r;
    end
    if (take_f) begin
      tok_nxt.f_found = 1'b1;
      tok_nxt.f_idx   = erd_pkg::CAR_W'(CELL_IDX);
      tok_nxt.f_gap   = gap_r;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r <= '0;
      count_r <= '0;
    end else begin
      if (cfg_sel) begin
        setup_r <= cfg_data;
      end
      if (inc) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign tok_out = tok_r;

endmodule

@@ src/elevator_request_dispatch.sv @@
// channel | direction | beat contents
// in      | request   | in_rider_tag, in_start_floor, in_end_floor
// out     | result    | out_tag_out, out_car_chosen, out_assigned, out_by_fallback
// cfg     | write     | cfg_index, cfg_data (one car setup per index)
// one request at a time; the cell row paces each beat: the request is scored in
// every cell at once, then the best-so-far record passes one cell per cycle down the row
// the result register frees the input side: the next request is taken while
// a result still waits, the walk holds at its end while the result is stalled
// synchronous active-low reset clears setups, occupant counts and control
module elevator_request_dispatch #(
  parameter int unsigned CAR_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [erd_pkg::TAG_W-1:0]     in_rider_tag,
  input  logic [erd_pkg::FLOOR_W-1:0]   in_start_floor,
  input  logic [erd_pkg::FLOOR_W-1:0]   in_end_floor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [erd_pkg::TAG_W-1:0]     out_tag_out,
  output logic [erd_pkg::CAR_W-1:0]     out_car_chosen,
  output logic                          out_assigned,
  output logic                          out_by_fallback,
  input  logic                          cfg_we,
  input  logic [erd_pkg::CAR_W-1:0]     cfg_index,
  input  logic [erd_pkg::SETUP_W-1:0]   cfg_data
);

  localparam int unsigned LIVE = (CAR_COUNT < erd_pkg::CAR_SLOTS) ? CAR_COUNT
                                                                   : erd_pkg::CAR_SLOTS;
  localparam int unsigned CW   = $clog2(LIVE + 1);

  erd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic [erd_pkg::TAG_W-1:0]   tag_r;
  logic [erd_pkg::FLOOR_W-1:0] start_r, end_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [erd_pkg::TAG_W-1:0]   out_tag_r;
  logic [erd_pkg::CAR_W-1:0]   out_car_r, car_pick;
  logic                        out_asg_r, out_fb_r;

  logic                        in_take, walk_done, load;
  erd_pkg::hop_t               chain [LIVE+1];
  erd_pkg::hop_t               res;

  assign in_take   = in_valid && in_ready;
  assign walk_done = (cnt_r == CW'(LIVE));
  assign chain[0]  = '0;
  assign res       = chain[LIVE];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      erd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = erd_pkg::ST_PREP;
      end
      erd_pkg::ST_PREP: begin
        state_nxt = erd_pkg::ST_WALK;
      end
      erd_pkg::ST_WALK: begin
        if (load) state_nxt = erd_pkg::ST_IDLE;
      end
      default: state_nxt = erd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    cnt_nxt  = '0;
    case (state_r)
      erd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      erd_pkg::ST_PREP: begin
        cnt_nxt = '0;
      end
      erd_pkg::ST_WALK: begin
        load    = walk_done && (!out_valid_r || out_ready);
        cnt_nxt = walk_done ? cnt_r : cnt_r + 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= erd_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tag_r   <= in_rider_tag;
      start_r <= in_start_floor;
      end_r   <= in_end_floor;
    end
  end

  genvar g;
  generate
    for (g = 0; g < LIVE; g++) begin : g_cell
      erd_cell #(
        .CELL_IDX (g)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_sel     (cfg_we && (cfg_index == erd_pkg::CAR_W'(g))),
        .cfg_data    (cfg_data),
        .start_floor (start_r),
        .end_floor   (end_r),
        .inc         (load && res.s_found && (res.s_idx == erd_pkg::CAR_W'(g))),
        .tok_in      (chain[g]),
        .tok_out     (chain[g+1])
      );
    end
  endgenerate

  always_comb begin
    if (res.s_found) begin
      car_pick = res.s_idx;
    end else if (res.f_found) begin
      car_pick = res.f_idx;
    end else begin
      car_pick = '0;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tag_r <= tag_r;
      out_car_r <= car_pick;
      out_asg_r <= res.s_found || res.f_found;
      out_fb_r  <= !res.s_found && res.f_found;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tag_out     = out_tag_r;
  assign out_car_chosen  = out_car_r;
  assign out_assigned    = out_asg_r;
  assign out_by_fallback = out_fb_r;

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == erd_pkg::ST_PREP)
    else $error("accepted request did not start scoring");

  a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == erd_pkg::ST_WALK))
    else $error("result appeared without a finished walk");

  a_unassigned_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_assigned |-> out_car_chosen == '0 && !out_by_fallback)
    else $error("unassigned result carries a car");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LIVE))
    else $error("walk counter past the cell row");

endmodule
